### sv/alu8_pkg.sv
// ----------------------------------------------------------------------------
// alu8_pkg
// Shared types and constants for the 8-bit ALU and flags unit: operation
// codes, status bit positions and the result bundle.
// ----------------------------------------------------------------------------
package alu8_pkg;

  localparam int unsigned CMD_W = 5;

  // Status bit positions: N V - B D I Z C
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADC = 5'd0,
    CMD_SBC = 5'd1,
    CMD_AND = 5'd2,
    CMD_ORA = 5'd3,
    CMD_EOR = 5'd4,
    CMD_ASL = 5'd5,
    CMD_ROL = 5'd6,
    CMD_ROR = 5'd7,
    CMD_CPX = 5'd8,
    CMD_CPY = 5'd9,
    CMD_INC = 5'd10,
    CMD_DEC = 5'd11,
    CMD_INX = 5'd12,
    CMD_INY = 5'd13,
    CMD_DEX = 5'd14,
    CMD_DEY = 5'd15,
    CMD_LDA = 5'd16,
    CMD_LDX = 5'd17,
    CMD_LDY = 5'd18,
    CMD_TAX = 5'd19,
    CMD_TXA = 5'd20,
    CMD_TAY = 5'd21,
    CMD_TYA = 5'd22,
    CMD_CLC = 5'd23,
    CMD_SEC = 5'd24,
    CMD_CLD = 5'd25,
    CMD_SED = 5'd26,
    CMD_CLI = 5'd27,
    CMD_SEI = 5'd28,
    CMD_CLV = 5'd29,
    CMD_NOP = 5'd30
  } cmd_t;

  typedef struct packed {
    logic [7:0] write_value;
    logic       write_enable;
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] status;
  } result_t;

endpackage

### sv/alu8_exec.sv
// ----------------------------------------------------------------------------
// alu8_exec
// Combinational execute step: given one operation and the current register
// file, produces the new registers, status byte and write-back byte.
// ----------------------------------------------------------------------------
module alu8_exec
  import alu8_pkg::*;
(
  input  logic [CMD_W-1:0] cmd,
  input  logic [7:0]       operand,
  input  logic             on_accumulator,
  input  logic [7:0]       acc,
  input  logic [7:0]       index_x,
  input  logic [7:0]       index_y,
  input  logic [7:0]       status,
  output result_t          res
);

  function automatic logic [7:0] with_nz(input logic [7:0] st, input logic [7:0] v);
    logic [7:0] r;
    r         = st;
    r[FLAG_N] = v[7];
    r[FLAG_Z] = (v == 8'h00);
    return r;
  endfunction

  logic       cin;
  assign cin = status[FLAG_C];

  // Binary add / subtract (subtract adds the inverted operand)
  logic [7:0] add_b;
  logic [8:0] bin;
  assign add_b = (cmd == CMD_SBC) ? ~operand : operand;
  assign bin   = {1'b0, acc} + {1'b0, add_b} + {8'h00, cin};

  logic       bin_v;
  assign bin_v = (acc[7] ^ bin[7]) & (add_b[7] ^ bin[7]);

  // Decimal add
  logic [4:0] dlo_raw;
  logic [4:0] dlo;
  logic [9:0] dt;
  logic [9:0] ds;
  logic [9:0] dt_adj;
  logic       dadd_v;
  assign dlo_raw = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'h0, cin};
  assign dlo     = (dlo_raw >= 5'd10) ? {1'b1, dlo_raw[3:0] + 4'd6} : dlo_raw;
  assign dt      = {2'b00, acc[7:4], 4'h0} + {2'b00, operand[7:4], 4'h0} + {5'h00, dlo};
  assign ds      = {{2{acc[7]}}, acc[7:4], 4'h0} + {{2{operand[7]}}, operand[7:4], 4'h0}
                 + {5'h00, dlo};
  assign dadd_v  = !((ds[9:7] == 3'b000) || (ds[9:7] == 3'b111));
  assign dt_adj  = (dt >= 10'h0A0) ? dt + 10'h060 : dt;

  // Decimal subtract (only A differs from binary)
  logic [5:0]  sl_raw;
  logic [10:0] sl;
  logic [10:0] st;
  logic [10:0] st_adj;
  assign sl_raw = {2'b00, acc[3:0]} - {2'b00, operand[3:0]} + {5'h00, cin} - 6'd1;
  assign sl     = sl_raw[5] ? {7'h7F, sl_raw[3:0] - 4'd6} : {{5{sl_raw[5]}}, sl_raw};
  assign st     = {3'b000, acc[7:4], 4'h0} - {3'b000, operand[7:4], 4'h0} + sl;
  assign st_adj = st[10] ? st - 11'h060 : st;

  // Shifts and rotates
  logic [7:0] sh_src;
  logic [7:0] sh_res;
  logic       sh_c;
  always_comb begin
    sh_src = on_accumulator ? acc : operand;
    if (cmd == CMD_ROR) begin
      sh_res = {cin, sh_src[7:1]};
      sh_c   = sh_src[0];
    end else begin
      sh_res = {sh_src[6:0], (cmd == CMD_ROL) ? cin : 1'b0};
      sh_c   = sh_src[7];
    end
  end

  // Compare
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  assign cmp_reg  = (cmd == CMD_CPY) ? index_y : index_x;
  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

  logic [7:0] inc_m;
  logic [7:0] dec_m;
  assign inc_m = operand + 8'd1;
  assign dec_m = operand - 8'd1;

  always_comb begin
    res.write_value  = 8'h00;
    res.write_enable = 1'b0;
    res.acc          = acc;
    res.x            = index_x;
    res.y            = index_y;
    res.status       = status;
    case (cmd)
      CMD_ADC: begin
        if (status[FLAG_D]) begin
          res.acc            = dt_adj[7:0];
          res.status[FLAG_V] = dadd_v;
          res.status[FLAG_N] = dt[7];
          res.status[FLAG_Z] = (bin[7:0] == 8'h00);
          res.status[FLAG_C] = (dt_adj[9:8] != 2'b00);
        end else begin
          res.acc            = bin[7:0];
          res.status         = with_nz(status, bin[7:0]);
          res.status[FLAG_V] = bin_v;
          res.status[FLAG_C] = bin[8];
        end
      end
      CMD_SBC: begin
        res.status         = with_nz(status, bin[7:0]);
        res.status[FLAG_V] = bin_v;
        res.status[FLAG_C] = bin[8];
        res.acc            = status[FLAG_D] ? st_adj[7:0] : bin[7:0];
      end
      CMD_AND: begin
        res.acc    = acc & operand;
        res.status = with_nz(status, acc & operand);
      end
      CMD_ORA: begin
        res.acc    = acc | operand;
        res.status = with_nz(status, acc | operand);
      end
      CMD_EOR: begin
        res.acc    = acc ^ operand;
        res.status = with_nz(status, acc ^ operand);
      end
      CMD_ASL, CMD_ROL, CMD_ROR: begin
        res.status         = with_nz(status, sh_res);
        res.status[FLAG_C] = sh_c;
        if (on_accumulator) begin
          res.acc = sh_res;
        end else begin
          res.write_value  = sh_res;
          res.write_enable = 1'b1;
        end
      end
      CMD_CPX, CMD_CPY: begin
        res.status         = with_nz(status, cmp_diff[7:0]);
        res.status[FLAG_C] = !cmp_diff[8];
      end
      CMD_INC: begin
        res.write_value  = inc_m;
        res.write_enable = 1'b1;
        res.status       = with_nz(status, inc_m);
      end
      CMD_DEC: begin
        res.write_value  = dec_m;
        res.write_enable = 1'b1;
        res.status       = with_nz(status, dec_m);
      end
      CMD_INX: begin
        res.x      = index_x + 8'd1;
        res.status = with_nz(status, index_x + 8'd1);
      end
      CMD_INY: begin
        res.y      = index_y + 8'd1;
        res.status = with_nz(status, index_y + 8'd1);
      end
      CMD_DEX: begin
        res.x      = index_x - 8'd1;
        res.status = with_nz(status, index_x - 8'd1);
      end
      CMD_DEY: begin
        res.y      = index_y - 8'd1;
        res.status = with_nz(status, index_y - 8'd1);
      end
      CMD_LDA: begin
        res.acc    = operand;
        res.status = with_nz(status, operand);
      end
      CMD_LDX: begin
        res.x      = operand;
        res.status = with_nz(status, operand);
      end
      CMD_LDY: begin
        res.y      = operand;
        res.status = with_nz(status, operand);
      end
      CMD_TAX: begin
        res.x      = acc;
        res.status = with_nz(status, acc);
      end
      CMD_TXA: begin
        res.acc    = index_x;
        res.status = with_nz(status, index_x);
      end
      CMD_TAY: begin
        res.y      = acc;
        res.status = with_nz(status, acc);
      end
      CMD_TYA: begin
        res.acc    = index_y;
        res.status = with_nz(status, index_y);
      end
      CMD_CLC: res.status[FLAG_C] = 1'b0;
      CMD_SEC: res.status[FLAG_C] = 1'b1;
      CMD_CLD: res.status[FLAG_D] = 1'b0;
      CMD_SED: res.status[FLAG_D] = 1'b1;
      CMD_CLI: res.status[FLAG_I] = 1'b0;
      CMD_SEI: res.status[FLAG_I] = 1'b1;
      CMD_CLV: res.status[FLAG_V] = 1'b0;
      default: begin
        // NOP and the unused code: nothing changes
      end
    endcase
  end

endmodule

### sv/eight_bit_cpu_alu_flags_unit.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_flags_unit
// Execute unit of an 8-bit accumulator processor: A, X, Y and status
// registers with ALU, BCD add/subtract, shifts, compares and flag ops.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_stall  | cmd, operand, on_accumulator
//  output  | out_valid / out_stall| write_value, write_enable, acc_out,
//          |                      | x_out, y_out, status_out
//
// One item per cycle sustained while out_stall is low. An item lands in the
// input register, goes through the execute logic into the result register
// (the register file updates on the same edge), and is shown from there.
// Reset (rst, synchronous) empties both stages and clears A, X, Y, status.
// A stalled result holds the output register; the input register keeps
// taking items until it too is full, then in_stall rises.
// ----------------------------------------------------------------------------
module eight_bit_cpu_alu_flags_unit
  import alu8_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] cmd,
  input  logic [7:0]       operand,
  input  logic             on_accumulator,
  // output channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       write_value,
  output logic             write_enable,
  output logic [7:0]       acc_out,
  output logic [7:0]       x_out,
  output logic [7:0]       y_out,
  output logic [7:0]       status_out
);

  // Input stage
  logic             in_full;
  logic [CMD_W-1:0] in_cmd;
  logic [7:0]       in_operand;
  logic             in_on_acc;

  // Architectural registers
  logic [7:0] acc;
  logic [7:0] index_x;
  logic [7:0] index_y;
  logic [7:0] status;

  // Result stage
  result_t out_res;

  logic    adv_out;   // result register can load this cycle
  logic    exec_go;   // item in input stage executes this cycle
  result_t exec_res;

  assign adv_out  = !out_valid || !out_stall;
  assign exec_go  = in_full && adv_out;
  assign in_stall = in_full && !adv_out;

  alu8_exec u_exec (
    .cmd            (in_cmd),
    .operand        (in_operand),
    .on_accumulator (in_on_acc),
    .acc            (acc),
    .index_x        (index_x),
    .index_y        (index_y),
    .status         (status),
    .res            (exec_res)
  );

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      acc       <= 8'h00;
      index_x   <= 8'h00;
      index_y   <= 8'h00;
      status    <= 8'h00;
    end else begin
      if (!in_stall) begin
        in_full <= in_valid;
      end
      if (adv_out) begin
        out_valid <= in_full;
      end
      // State commits as the item moves into the result register, so the
      // next item in the input stage already sees it.
      if (exec_go) begin
        acc     <= exec_res.acc;
        index_x <= exec_res.x;
        index_y <= exec_res.y;
        status  <= exec_res.status;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_cmd     <= cmd;
      in_operand <= operand;
      in_on_acc  <= on_accumulator;
    end
    if (exec_go) begin
      out_res <= exec_res;
    end
  end

  assign write_value  = out_res.write_value;
  assign write_enable = out_res.write_enable;
  assign acc_out      = out_res.acc;
  assign x_out        = out_res.x;
  assign y_out        = out_res.y;
  assign status_out   = out_res.status;

endmodule
